[hdl/rfa_pkg.sv]
// rfa_pkg: shared types, widths and codes of the rational fraction alu
// no dependencies; imported by every other file of the block
`default_nettype none

package rfa_pkg;

    localparam int VALUE_BITS = 32;

    // port field widths are fixed
    localparam int FIELD_W = 32;
    localparam int DEN_W   = 31;

    localparam int VW = VALUE_BITS;
    localparam int PW = 2 * VALUE_BITS;
    localparam int QB = VALUE_BITS - 1;
    localparam int KW = $clog2(PW + 1);
    localparam int CW = $clog2(QB + 1);

    // largest legal magnitude, at the port width plus one
    localparam logic signed [FIELD_W:0] LIM = (FIELD_W + 1)'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_INVALID  = 2'd1;
    localparam status_t ST_DIVZERO  = 2'd2;
    localparam status_t ST_OVERFLOW = 2'd3;

    // classified operation waiting for the back end
    typedef struct packed {
        op_t                  op;
        logic signed [VW-1:0] an;
        logic signed [VW-1:0] ad;
        logic signed [VW-1:0] bn;
        logic signed [VW-1:0] bd;
        status_t              status;
    } item_t;

    typedef struct packed {
        logic  push;
        logic  pop;
    } queue_ctl_t;

endpackage

`default_nettype wire

[hdl/rfa_if.sv]
// rfa_if: valid/ready channels for operand beats and result beats
// depends on rfa_pkg for field widths
`default_nettype none

interface rfa_in_if;
    import rfa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if;
    import rfa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] res_num;
    logic [DEN_W-1:0]          res_den;
    logic [1:0]                status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink (input valid, res_num, res_den, status, output ready);
endinterface

`default_nettype wire

[hdl/rfa_front.sv]
// rfa_front: checks raw operands, moves signs to numerators, builds queue items
// depends on rfa_pkg and rfa_if
`default_nettype none

module rfa_front
    import rfa_pkg::*;
(
    rfa_in_if.sink   in_ch,
    input  wire logic q_full,
    output item_t     item,
    output logic      push
);

    logic bad_range;
    logic signed [VW-1:0] an_t;
    logic signed [VW-1:0] ad_t;
    logic signed [VW-1:0] bn_t;
    logic signed [VW-1:0] bd_t;

    function automatic logic out_of_range(input logic signed [FIELD_W-1:0] v);
        logic signed [FIELD_W:0] w;
        w = (FIELD_W + 1)'(v);
        return (w > LIM) || (w < -LIM);
    endfunction

    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;

    always_comb
    begin
        bad_range = out_of_range(in_ch.a_num) || out_of_range(in_ch.a_den)
                 || out_of_range(in_ch.b_num) || out_of_range(in_ch.b_den);
        an_t = VW'(in_ch.a_num);
        ad_t = VW'(in_ch.a_den);
        bn_t = VW'(in_ch.b_num);
        bd_t = VW'(in_ch.b_den);
        item.op = in_ch.operation;
        // denominators made positive
        item.an = ad_t[VW-1] ? -an_t : an_t;
        item.ad = ad_t[VW-1] ? -ad_t : ad_t;
        item.bn = bd_t[VW-1] ? -bn_t : bn_t;
        item.bd = bd_t[VW-1] ? -bd_t : bd_t;
        if (in_ch.a_den == '0 || in_ch.b_den == '0)
        begin
            item.status = ST_INVALID;
        end
        else if (bad_range)
        begin
            item.status = ST_OVERFLOW;
        end
        else if (in_ch.operation == OP_DIV && in_ch.b_num == '0)
        begin
            item.status = ST_DIVZERO;
        end
        else
        begin
            item.status = ST_OK;
        end
    end

endmodule

`default_nettype wire

[hdl/rfa_queue.sv]
// rfa_queue: short register queue between front and back end
// depends on rfa_pkg
`default_nettype none

module rfa_queue
    import rfa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  queue_ctl_t ctl,
    input  item_t      wr_item,
    output item_t      rd_item,
    output logic       full,
    output logic       empty
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [PTR_W:0]    cnt_reg;

    assign full    = cnt_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_item = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem_reg[wr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (ctl.push && !ctl.pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (ctl.pop && !ctl.push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/rfa_back.sv]
// rfa_back: cross products on one multiplier, binary gcd, radix-2 division
// depends on rfa_pkg and rfa_if; drives the result register
`default_nettype none

module rfa_back
    import rfa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  item_t      q_item,
    input  wire logic  q_empty,
    output logic       pop,
    rfa_out_if.source  out_ch
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_ABS  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DCHK = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]           state_reg;
    item_t                cur_reg;
    logic signed [PW-1:0] t1_reg;
    logic signed [PW-1:0] t2_reg;
    logic signed [PW-1:0] q_reg;
    logic signed [PW-1:0] p_reg;
    logic [PW-1:0]        mp_reg;
    logic [PW-1:0]        mq_reg;
    logic                 neg_reg;
    logic [PW-1:0]        gx_reg;
    logic [PW-1:0]        gy_reg;
    logic [KW-1:0]        k_reg;
    logic [PW-1:0]        g_reg;
    logic [PW-1:0]        remn_reg;
    logic [PW-1:0]        remd_reg;
    logic [QB-1:0]        qn_reg;
    logic [QB-1:0]        qd_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [VW-1:0] rnum_reg;
    logic [QB-1:0]        rden_reg;
    status_t              rst_reg;

    logic                 ovalid_reg;
    logic signed [FIELD_W-1:0] onum_reg;
    logic [DEN_W-1:0]     oden_reg;
    status_t              ost_reg;

    logic signed [VW-1:0] mul_a;
    logic signed [VW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        trial_n;
    logic [PW-1:0]        trial_d;
    logic [VW-1:0]        qn_ext;
    logic                 out_free;

    assign out_free       = !ovalid_reg || out_ch.ready;
    assign pop            = state_reg == S_IDLE && !q_empty;
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.res_num = onum_reg;
    assign out_ch.res_den = oden_reg;
    assign out_ch.status  = ost_reg;

    always_comb
    begin
        unique case (state_reg)
            S_MUL1:
            begin
                mul_a = cur_reg.an;
                mul_b = (cur_reg.op == OP_MUL) ? cur_reg.bn : cur_reg.bd;
            end
            S_MUL2:
            begin
                mul_a = cur_reg.bn;
                mul_b = cur_reg.ad;
            end
            default:
            begin
                mul_a = cur_reg.ad;
                mul_b = (cur_reg.op == OP_DIV) ? cur_reg.bn : cur_reg.bd;
            end
        endcase
        prod    = PW'(mul_a) * PW'(mul_b);
        trial_n = {remn_reg[PW-2:0], qn_reg[QB-1]};
        trial_d = {remd_reg[PW-2:0], qd_reg[QB-1]};
        qn_ext  = VW'(qn_reg);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cur_reg <= q_item;
            end
            S_MUL1:
            begin
                t1_reg <= prod;
            end
            S_MUL2:
            begin
                t2_reg <= (cur_reg.op == OP_ADD || cur_reg.op == OP_SUB) ? prod : '0;
            end
            S_MUL3:
            begin
                q_reg <= prod;
            end
            S_SUM:
            begin
                p_reg <= (cur_reg.op == OP_SUB) ? t1_reg - t2_reg : t1_reg + t2_reg;
            end
            S_ABS:
            begin
                mp_reg  <= p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
                mq_reg  <= q_reg[PW-1] ? PW'(-q_reg) : PW'(q_reg);
                gx_reg  <= p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
                gy_reg  <= q_reg[PW-1] ? PW'(-q_reg) : PW'(q_reg);
                neg_reg <= p_reg[PW-1] ^ q_reg[PW-1];
                k_reg   <= '0;
            end
            S_GCD:
            begin
                // binary gcd, one step a cycle
                if (gx_reg == gy_reg)
                begin
                    g_reg <= gx_reg << k_reg;
                end
                else if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    k_reg  <= k_reg + 1'b1;
                end
                else if (!gx_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_reg <= gy_reg >> 1;
                end
                else if (gx_reg > gy_reg)
                begin
                    gx_reg <= gx_reg - gy_reg;
                end
                else
                begin
                    gy_reg <= gy_reg - gx_reg;
                end
            end
            S_DCHK:
            begin
                remn_reg <= mp_reg >> QB;
                remd_reg <= mq_reg >> QB;
                qn_reg   <= mp_reg[QB-1:0];
                qd_reg   <= mq_reg[QB-1:0];
                cnt_reg  <= CW'(QB);
            end
            S_DIV:
            begin
                // dividend bits shift out at the top as quotient bits shift in
                if (trial_n >= g_reg)
                begin
                    remn_reg <= trial_n - g_reg;
                    qn_reg   <= {qn_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    remn_reg <= trial_n;
                    qn_reg   <= {qn_reg[QB-2:0], 1'b0};
                end
                if (trial_d >= g_reg)
                begin
                    remd_reg <= trial_d - g_reg;
                    qd_reg   <= {qd_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    remd_reg <= trial_d;
                    qd_reg   <= {qd_reg[QB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase

        // result staging
        if (state_reg == S_MUL1 && cur_reg.status != ST_OK)
        begin
            rnum_reg <= '0;
            rden_reg <= '0;
            rst_reg  <= cur_reg.status;
        end
        else if (state_reg == S_ABS && p_reg == '0)
        begin
            rnum_reg <= '0;
            rden_reg <= QB'(1);
            rst_reg  <= ST_OK;
        end
        else if (state_reg == S_DCHK && ((mp_reg >> QB) >= g_reg || (mq_reg >> QB) >= g_reg))
        begin
            rnum_reg <= '0;
            rden_reg <= '0;
            rst_reg  <= ST_OVERFLOW;
        end
        else if (state_reg == S_DIV && cnt_reg == CW'(1))
        begin
            rst_reg <= ST_OK;
        end
        else if (state_reg == S_DONE)
        begin
            rnum_reg <= rnum_reg;
        end
    end

    // final numerator with its sign, once the quotients are complete
    logic signed [VW-1:0] fin_num;
    assign fin_num = neg_reg ? -$signed(qn_ext) : $signed(qn_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    state_reg <= (cur_reg.status != ST_OK) ? S_DONE : S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    state_reg <= (p_reg == '0) ? S_DONE : S_GCD;
                end
                S_GCD:
                begin
                    if (gx_reg == gy_reg)
                    begin
                        state_reg <= S_DCHK;
                    end
                end
                S_DCHK:
                begin
                    if ((mp_reg >> QB) >= g_reg || (mq_reg >> QB) >= g_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // division result is taken from the quotient registers when the loop ends
    // and stays selected while the finished item waits for the output register
    logic div_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_done_reg <= 1'b0;
        end
        else
        begin
            div_done_reg <= (state_reg == S_DIV && cnt_reg == CW'(1))
                         || (div_done_reg && state_reg == S_DONE && !out_free);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            if (div_done_reg)
            begin
                onum_reg <= FIELD_W'(fin_num);
                oden_reg <= DEN_W'(qd_reg);
            end
            else
            begin
                onum_reg <= FIELD_W'(rnum_reg);
                oden_reg <= DEN_W'(rden_reg);
            end
            ost_reg <= rst_reg;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GCD |-> (gx_reg != '0 && gy_reg != '0))
        else $error("gcd operand reached zero");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ost_reg == ST_OK) |-> oden_reg != '0)
        else $error("ok result with zero denominator");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ost_reg != ST_OK) |-> (onum_reg == '0 && oden_reg == '0))
        else $error("error result with nonzero fields");
`endif

endmodule

`default_nettype wire

[hdl/rational_fraction_alu.sv]
// rational_fraction_alu: top level, front end, queue and back end
// depends on rfa_pkg, rfa_if, rfa_front, rfa_queue, rfa_back
//
// One beat in gives one beat out: a op b on two raw signed fractions, reduced to lowest
// terms with the sign on the numerator, or a zero result with an error status. The back
// end runs the cross products on the single 32x32 multiplier, a binary gcd loop of one
// step a cycle over the 64-bit cross products, then radix-2 division. Error items skip
// straight to the result, and a zero numerator skips the gcd loop and the division. A
// two-beat queue lets the front accept new operands while the back end works and while
// a result waits in the output register.
`default_nettype none

module rational_fraction_alu
    import rfa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rfa_in_if.sink    in_ch,
    rfa_out_if.source out_ch
);

    item_t      f_item;
    item_t      q_item;
    logic       q_full;
    logic       q_empty;
    queue_ctl_t q_ctl;
    logic       push;
    logic       pop;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    rfa_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .item   (f_item),
        .push   (push)
    );

    rfa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .wr_item (f_item),
        .rd_item (q_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    rfa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire
